### design/first_fit_block_allocator_unit_defines.svh
// Assertion macros shared by the allocator RTL.
// Expects clk and rst_n in the scope of the module that uses them.
`ifndef FIRST_FIT_BLOCK_ALLOCATOR_UNIT_DEFINES_SVH
`define FIRST_FIT_BLOCK_ALLOCATOR_UNIT_DEFINES_SVH

// checked only outside reset
`define FFBA_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked on every edge, reset included
`define FFBA_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### design/ffba_pkg.sv
// Shared constants, types and helpers for the first-fit block allocator.
// No dependencies.
package ffba_pkg;

  localparam int unsigned TABLE_DEPTH = 1024;
  // block size must be a power of two
  localparam int unsigned BLOCK_BYTES = 4096;
  localparam int unsigned BLOCK_SHIFT = $clog2(BLOCK_BYTES);

  localparam int unsigned ADDR_W = 32;
  localparam int unsigned IDX_W  = $clog2(TABLE_DEPTH);
  localparam int unsigned CNT_W  = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned NB_W   = 11;
  localparam int unsigned NB_MAX = (1 << NB_W) - 1;
  localparam int unsigned NEED_W = ADDR_W + 1 - BLOCK_SHIFT;
  localparam int unsigned CFG_IDX_W = 1;

  typedef enum logic {
    CMD_ALLOC = 1'b0,
    CMD_FREE  = 1'b1
  } cmd_t;

  typedef enum logic {
    STAT_DONE = 1'b0,
    STAT_FAIL = 1'b1
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_HEAP_BASE  = 1'b0,
    REG_NUM_BLOCKS = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    cmd_t              cmd;
    logic [ADDR_W-1:0] size_bytes;
    logic [ADDR_W-1:0] address;
  } in_word_t;

  typedef struct packed {
    status_t           status;
    logic [ADDR_W-1:0] alloc_address;
  } out_word_t;

  // one table entry
  typedef struct packed {
    logic has_next;
    logic first;
    logic taken;
  } flags_t;

  localparam int unsigned FLAGS_W = $bits(flags_t);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DECODE,
    ST_SCAN,
    ST_MARK,
    ST_FREE_RD,
    ST_FREE_WR,
    ST_RESP
  } state_t;

  // sequencer -> run unit
  typedef struct packed {
    logic             clear;
    logic             step;
    logic             entry_free;
    logic [IDX_W-1:0] idx;
  } run_ctrl_t;

  // run unit -> sequencer
  typedef struct packed {
    logic             hit;
    logic [IDX_W-1:0] start;
  } run_stat_t;

  function automatic logic [CNT_W-1:0] clamp_blocks(input logic [NB_W-1:0] v);
    logic [31:0] w;
    w = 32'(v);
    if (w > 32'(TABLE_DEPTH)) begin
      w = 32'(TABLE_DEPTH);
    end
    return CNT_W'(w);
  endfunction

  localparam logic [NB_W-1:0] NB_RESET =
    (TABLE_DEPTH > NB_MAX) ? NB_W'(NB_MAX) : NB_W'(TABLE_DEPTH);

endpackage

### design/ffba_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module ffba_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

### design/ffba_run_unit.sv
// Free-run counter and compare unit used by the first-fit scan.
// Depends on ffba_pkg.
module ffba_run_unit (
  input  logic                        clk,
  input  logic                        rst_n,
  input  ffba_pkg::run_ctrl_t         ctrl,
  input  logic [ffba_pkg::CNT_W-1:0]  need,
  output ffba_pkg::run_stat_t         stat
);

  logic [ffba_pkg::CNT_W-1:0] run_r;
  logic [ffba_pkg::IDX_W-1:0] start_r;
  logic [ffba_pkg::CNT_W-1:0] run_inc;

  assign run_inc    = run_r + ffba_pkg::CNT_W'(1);
  // a new run starts at the current entry
  assign stat.start = (run_r == '0) ? ctrl.idx : start_r;
  assign stat.hit   = ctrl.step && ctrl.entry_free && (run_inc == need);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r <= '0;
    end else if (ctrl.clear) begin
      run_r <= '0;
    end else if (ctrl.step) begin
      run_r <= ctrl.entry_free ? run_inc : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.step && ctrl.entry_free) begin
      start_r <= stat.start;
    end
  end

endmodule

### design/first_fit_block_allocator_unit.sv
// Top level of the first-fit block allocator: sequencer, config regs, result register.
// Depends on ffba_pkg, ffba_ram, ffba_run_unit and the defines header.
//
//  channel  | ports                          | dir | flow
//  ---------+--------------------------------+-----+------------------
//  in       | in_valid  in_stall  in_word    | in  | valid / stall
//  out      | out_valid out_stall out_word   | out | valid / stall
//  cfg      | cfg_valid cfg_ready cfg_index  | in  | valid / ready
//           | cfg_data                       |     |
//
// After reset the table is swept clear, one entry a cycle, while in_stall stays high;
// cfg writes are taken throughout.
// Allocate: the scan reads from entry 0 and marks the first run that fits (start = its
// first block), else fails; the table RAM's single read port gives one entry a cycle.
// Free clears the chain in turn; out-of-heap frees and failed size checks skip the table.
// A new word is taken while a finished result waits on out_stall; the next result then
// holds in the sequencer until the output register empties.
`include "first_fit_block_allocator_unit_defines.svh"

module first_fit_block_allocator_unit (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  ffba_pkg::in_word_t                in_word,
  output logic                              out_valid,
  input  logic                              out_stall,
  output ffba_pkg::out_word_t               out_word,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [ffba_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [ffba_pkg::ADDR_W-1:0]       cfg_data
);

  ffba_pkg::state_t                state_r, state_nxt;
  logic [ffba_pkg::CNT_W-1:0]      idx_r, idx_nxt;
  logic [ffba_pkg::IDX_W-1:0]      chk_idx_r, chk_idx_nxt;
  logic                            vld_r, vld_nxt;
  logic [ffba_pkg::CNT_W-1:0]      left_r, left_nxt;
  logic                            first_r, first_nxt;
  logic [ffba_pkg::IDX_W-1:0]      start_r, start_nxt;
  logic [ffba_pkg::CNT_W-1:0]      need_r, need_nxt;
  ffba_pkg::in_word_t              in_r, in_nxt;
  ffba_pkg::out_word_t             pend_r, pend_nxt;
  logic                            out_valid_r, out_valid_nxt;
  ffba_pkg::out_word_t             out_word_r, out_word_nxt;
  logic [ffba_pkg::ADDR_W-1:0]     heap_base_r;
  logic [ffba_pkg::CNT_W-1:0]      used_r;

  logic                            ram_wr_en;
  logic [ffba_pkg::IDX_W-1:0]      ram_wr_addr;
  ffba_pkg::flags_t                ram_wr_data;
  logic                            ram_rd_en;
  logic [ffba_pkg::IDX_W-1:0]      ram_rd_addr;
  logic [ffba_pkg::FLAGS_W-1:0]    ram_rd_data;
  ffba_pkg::flags_t                rd_flags;

  ffba_pkg::run_ctrl_t             run_ctrl;
  ffba_pkg::run_stat_t             run_stat;

  logic [ffba_pkg::NEED_W-1:0]     need_full;
  logic                            alloc_bad;
  logic [ffba_pkg::ADDR_W-1:0]     free_off;
  logic [ffba_pkg::ADDR_W-1:0]     free_idx;
  logic                            free_oob;
  logic                            issue;
  logic [ffba_pkg::CNT_W-1:0]      idx_inc;

  assign in_stall  = (state_r != ffba_pkg::ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;
  assign cfg_ready = 1'b1;
  assign rd_flags  = ffba_pkg::flags_t'(ram_rd_data);
  assign idx_inc   = idx_r + ffba_pkg::CNT_W'(1);

  // round size up to whole blocks; 33-bit sum so the top size does not wrap
  assign need_full = ffba_pkg::NEED_W'(({1'b0, in_r.size_bytes}
                     + (ffba_pkg::ADDR_W + 1)'(ffba_pkg::BLOCK_BYTES - 1))
                     >> ffba_pkg::BLOCK_SHIFT);
  assign alloc_bad = (need_full == '0)
                     || ((ffba_pkg::ADDR_W + 1)'(need_full) > (ffba_pkg::ADDR_W + 1)'(used_r));
  assign free_off  = in_r.address - heap_base_r;
  assign free_idx  = free_off >> ffba_pkg::BLOCK_SHIFT;
  assign free_oob  = free_idx >= ffba_pkg::ADDR_W'(used_r);
  assign issue     = (state_r == ffba_pkg::ST_SCAN) && (idx_r < used_r);

  ffba_ram #(
    .WIDTH (ffba_pkg::FLAGS_W),
    .DEPTH (ffba_pkg::TABLE_DEPTH)
  ) u_table (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  ffba_run_unit u_run (
    .clk   (clk),
    .rst_n (rst_n),
    .ctrl  (run_ctrl),
    .need  (need_r),
    .stat  (run_stat)
  );

  always_comb begin
    state_nxt     = state_r;
    idx_nxt       = idx_r;
    chk_idx_nxt   = chk_idx_r;
    vld_nxt       = 1'b0;
    left_nxt      = left_r;
    first_nxt     = first_r;
    start_nxt     = start_r;
    need_nxt      = need_r;
    in_nxt        = in_r;
    pend_nxt      = pend_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_word_nxt  = out_word_r;

    ram_wr_en     = 1'b0;
    ram_wr_addr   = idx_r[ffba_pkg::IDX_W-1:0];
    ram_wr_data   = '0;
    ram_rd_en     = 1'b0;
    ram_rd_addr   = idx_r[ffba_pkg::IDX_W-1:0];

    run_ctrl.clear      = 1'b0;
    run_ctrl.step       = 1'b0;
    run_ctrl.entry_free = (rd_flags == '0);
    run_ctrl.idx        = chk_idx_r;

    case (state_r)
      ffba_pkg::ST_CLEAR: begin
        ram_wr_en = 1'b1;
        idx_nxt   = idx_inc;
        if (idx_r == ffba_pkg::CNT_W'(ffba_pkg::TABLE_DEPTH - 1)) begin
          state_nxt = ffba_pkg::ST_IDLE;
        end
      end
      ffba_pkg::ST_IDLE: begin
        if (in_valid) begin
          in_nxt    = in_word;
          state_nxt = ffba_pkg::ST_DECODE;
        end
      end
      ffba_pkg::ST_DECODE: begin
        pend_nxt.status        = ffba_pkg::STAT_DONE;
        pend_nxt.alloc_address = '0;
        if (in_r.cmd == ffba_pkg::CMD_ALLOC) begin
          if (alloc_bad) begin
            pend_nxt.status = ffba_pkg::STAT_FAIL;
            state_nxt       = ffba_pkg::ST_RESP;
          end else begin
            need_nxt       = ffba_pkg::CNT_W'(need_full);
            run_ctrl.clear = 1'b1;
            idx_nxt        = '0;
            state_nxt      = ffba_pkg::ST_SCAN;
          end
        end else begin
          if (free_oob) begin
            state_nxt = ffba_pkg::ST_RESP;
          end else begin
            idx_nxt   = ffba_pkg::CNT_W'(free_idx);
            state_nxt = ffba_pkg::ST_FREE_RD;
          end
        end
      end
      ffba_pkg::ST_SCAN: begin
        // read one entry ahead while the previous one is checked
        ram_rd_en     = issue;
        vld_nxt       = issue;
        chk_idx_nxt   = idx_r[ffba_pkg::IDX_W-1:0];
        run_ctrl.step = vld_r;
        if (issue) begin
          idx_nxt = idx_inc;
        end
        if (run_stat.hit) begin
          idx_nxt   = ffba_pkg::CNT_W'(run_stat.start);
          start_nxt = run_stat.start;
          left_nxt  = need_r;
          first_nxt = 1'b1;
          vld_nxt   = 1'b0;
          state_nxt = ffba_pkg::ST_MARK;
        end else if (!issue && !vld_r) begin
          pend_nxt.status = ffba_pkg::STAT_FAIL;
          state_nxt       = ffba_pkg::ST_RESP;
        end
      end
      ffba_pkg::ST_MARK: begin
        ram_wr_en            = 1'b1;
        ram_wr_data.taken    = 1'b1;
        ram_wr_data.first    = first_r;
        ram_wr_data.has_next = (left_r != ffba_pkg::CNT_W'(1));
        idx_nxt              = idx_inc;
        left_nxt             = left_r - ffba_pkg::CNT_W'(1);
        first_nxt            = 1'b0;
        if (left_r == ffba_pkg::CNT_W'(1)) begin
          pend_nxt.status        = ffba_pkg::STAT_DONE;
          pend_nxt.alloc_address = heap_base_r
                                   + (ffba_pkg::ADDR_W'(start_r) << ffba_pkg::BLOCK_SHIFT);
          state_nxt              = ffba_pkg::ST_RESP;
        end
      end
      ffba_pkg::ST_FREE_RD: begin
        ram_rd_en = 1'b1;
        state_nxt = ffba_pkg::ST_FREE_WR;
      end
      ffba_pkg::ST_FREE_WR: begin
        ram_wr_en = 1'b1;
        if (rd_flags.has_next && (idx_inc < used_r)) begin
          idx_nxt   = idx_inc;
          state_nxt = ffba_pkg::ST_FREE_RD;
        end else begin
          state_nxt = ffba_pkg::ST_RESP;
        end
      end
      ffba_pkg::ST_RESP: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_word_nxt  = pend_r;
          state_nxt     = ffba_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = ffba_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ffba_pkg::ST_CLEAR;
      idx_r       <= '0;
      vld_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      vld_r       <= vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    chk_idx_r  <= chk_idx_nxt;
    left_r     <= left_nxt;
    first_r    <= first_nxt;
    start_r    <= start_nxt;
    need_r     <= need_nxt;
    in_r       <= in_nxt;
    pend_r     <= pend_nxt;
    out_word_r <= out_word_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      heap_base_r <= '0;
      used_r      <= ffba_pkg::clamp_blocks(ffba_pkg::NB_RESET);
    end else if (cfg_valid && cfg_ready) begin
      case (ffba_pkg::cfg_reg_t'(cfg_index))
        ffba_pkg::REG_HEAP_BASE: begin
          heap_base_r <= cfg_data;
        end
        ffba_pkg::REG_NUM_BLOCKS: begin
          used_r <= ffba_pkg::clamp_blocks(cfg_data[ffba_pkg::NB_W-1:0]);
        end
        default: begin
        end
      endcase
    end
  end

  `FFBA_ASSERT(a_hit_in_heap,
    run_stat.hit |-> (ffba_pkg::CNT_W'(chk_idx_r) < used_r),
    "scan hit beyond blocks in use")
  `FFBA_ASSERT(a_wr_in_heap,
    (ram_wr_en && state_r != ffba_pkg::ST_CLEAR) |-> (idx_r < used_r),
    "table write beyond blocks in use")
  `FFBA_ASSERT(a_mark_left,
    (state_r == ffba_pkg::ST_MARK) |-> (left_r != '0),
    "mark with no blocks left")
  `FFBA_ASSERT(a_mark_ends,
    (state_r == ffba_pkg::ST_MARK && left_r == ffba_pkg::CNT_W'(1))
      |=> (state_r == ffba_pkg::ST_RESP && pend_r.status == ffba_pkg::STAT_DONE),
    "last mark did not lead to a done result")
  `FFBA_ASSERT_RST(a_reset_clears,
    !rst_n |=> (state_r == ffba_pkg::ST_CLEAR && !out_valid_r),
    "reset did not start the clearing sweep")

endmodule
